FILE: rtl/pcht_pkg.sv
package pcht_pkg;

   // coordinate, chord endpoint, multiplier, accumulator and other datapath widths
   localparam int CW  = 24;
   localparam int HWW = 23;
   localparam int QW  = 25;
   localparam int PW  = 26;
   localparam int DXW = 33;
   localparam int TWW = 18;
   localparam int MW  = 34;
   localparam int AW  = 66;
   localparam int DW  = 64;
   localparam int DVW = 32;
   localparam int LW  = 27;
   localparam int SW  = 16;
   localparam int TW  = 17;
   localparam int CNTW = 16;

   localparam int ROUND_SHIFT = 32;
   localparam int TAN_SHIFT   = 9;
   localparam int LEN_SHIFT   = 9;

   localparam logic signed [MW-1:0] WEIGHT_ONE = 34'sh1_0000_0000;
   localparam logic [DW-1:0]        T_ONE      = 64'd65536;

   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_LINE,
      KIND_CURVE,
      KIND_STROKE
   } pcht_kind_type;

   typedef enum logic {
      REG_TEST_X,
      REG_TEST_Y
   } pcht_reg_type;

   typedef enum logic {
      DS_DIV,
      DS_SQRT
   } pcht_ds_op_type;

   typedef struct packed {
      logic           start;
      pcht_ds_op_type op;
   } pcht_ds_req_type;

   typedef enum logic [1:0] {
      DOT_BEZ_X,
      DOT_BEZ_Y,
      DOT_TAN_X,
      DOT_TAN_Y
   } pcht_dot_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_CHK,
      ST_L1, ST_L2, ST_L3, ST_L4, ST_L5,
      ST_NSTEP, ST_NDIV, ST_NWAIT,
      ST_W1, ST_W2, ST_W3, ST_W4,
      ST_D0, ST_D1, ST_D2, ST_D3,
      ST_QX, ST_QY,
      ST_PCH, ST_PNEXT, ST_PFIN,
      ST_TX, ST_TY,
      ST_N1, ST_N2, ST_N3, ST_N4, ST_N5,
      ST_O1, ST_O2, ST_O3, ST_O4, ST_O5, ST_O6,
      ST_FCA, ST_FCB, ST_FNEXT, ST_FFA, ST_FFB,
      ST_CH1, ST_CH2, ST_CH3,
      ST_DONE
   } pcht_state_type;

endpackage

FILE: rtl/path_crossing_hit_test_unit.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  kind, p0..p2, half_width, start/end offsets
// rsp      out        rsp_valid/rsp_stall  crossing_count, inside_res
// csr      in         csr_write            csr_index, csr_data (test_x, test_y)
//
// One item at a time; req_stall is high from acceptance until the result is queued.
// A line item runs one chord through the shared multiplier; curve and stroke
// items also use the bit-serial divide/root unit.
// Reset is synchronous: count and test point go to zero.
// The result sits in an output register; the next item is taken while it waits.
module path_crossing_hit_test_unit import pcht_pkg::*; #(
   parameter int MAX_STEPS = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic                  csr_index,
   input  logic [CW-1:0]         csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic signed [CW-1:0]  req_p0_x,
   input  logic signed [CW-1:0]  req_p0_y,
   input  logic signed [CW-1:0]  req_p1_x,
   input  logic signed [CW-1:0]  req_p1_y,
   input  logic signed [CW-1:0]  req_p2_x,
   input  logic signed [CW-1:0]  req_p2_y,
   input  logic [HWW-1:0]        req_half_width,
   input  logic signed [CW-1:0]  req_start_off_x,
   input  logic signed [CW-1:0]  req_start_off_y,
   input  logic signed [CW-1:0]  req_end_off_x,
   input  logic signed [CW-1:0]  req_end_off_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CNTW-1:0]       rsp_crossing_count,
   output logic                  rsp_inside_res
);

   localparam int NW = $clog2(MAX_STEPS + 1);
   localparam int SLW = LW - LEN_SHIFT;

   // sequencer
   pcht_state_type state_ff, state_in;
   pcht_state_type ret_ff, ret_in;
   pcht_dot_type   dot_ff, dot_in;

   // item registers
   pcht_kind_type         kind_ff, kind_in;
   logic signed [CW-1:0]  p0x_ff, p0x_in, p0y_ff, p0y_in;
   logic signed [CW-1:0]  p1x_ff, p1x_in, p1y_ff, p1y_in;
   logic signed [CW-1:0]  p2x_ff, p2x_in, p2y_ff, p2y_in;
   logic [HWW-1:0]        hw_ff, hw_in;
   logic signed [CW-1:0]  sox_ff, sox_in, soy_ff, soy_in;
   logic signed [CW-1:0]  eox_ff, eox_in, eoy_ff, eoy_in;

   // test point and count
   logic signed [CW-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [CNTW-1:0]       cross_ff, cross_in;

   // shared multiplier and accumulator
   logic signed [MW-1:0]  mul_a, mul_b;
   logic signed [2*MW-1:0] mul_full;
   logic signed [AW-1:0]  prod_ff, prod_in;
   logic signed [AW-1:0]  acc_ff, acc_in;

   // flattening state
   logic [LW-1:0]         len_ff, len_in;
   logic                  lenb_ff, lenb_in;
   logic [NW-1:0]         n_ff, n_in, k_ff, k_in;
   logic [SW-1:0]         step_ff, step_in;
   logic [TW-1:0]         t_ff, t_in;
   logic signed [MW-1:0]  w0_ff, w0_in, w1_ff, w1_in, w2_ff, w2_in;
   logic signed [TWW-1:0] tw0_ff, tw0_in, tw1_ff, tw1_in, tw2_ff, tw2_in;
   logic signed [QW-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic signed [DXW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DVW-1:0]        nm_ff, nm_in;
   logic signed [QW-1:0]  ox_ff, ox_in, oy_ff, oy_in;
   logic                  neg_ff, neg_in;

   // chord endpoints and chain tails
   logic signed [PW-1:0]  ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [PW-1:0]  lax_ff, lax_in, lay_ff, lay_in, lbx_ff, lbx_in, lby_ff, lby_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0]       rsp_count_ff, rsp_count_in;

   // divide / root unit
   pcht_ds_req_type       ds_req;
   logic [DW-1:0]         ds_a;
   logic [DVW-1:0]        ds_b;
   logic                  ds_done;
   logic [DW-1:0]         ds_res;

   // helpers
   logic                  accept;
   logic                  out_free;
   logic signed [CW:0]    ex, ey;
   logic signed [PW-1:0]  ty_ext, lo_y, hi_y;
   logic                  skip;
   logic                  straddle;
   logic                  hit;
   logic signed [AW-1:0]  rsum, tsum;
   logic [AW-1:0]         prod_mag;
   logic [TW-1:0]         u_val;
   logic [SLW-1:0]        slen;
   logic [NW-1:0]         n_clamped;
   logic signed [QW-1:0]  qmag;
   logic signed [MW-1:0]  dot_c0, dot_c1, dot_c2, dot_w0, dot_w1, dot_w2;
   logic signed [MW-1:0]  hw_op;

   pcht_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .req   (ds_req),
      .a     (ds_a),
      .b     (ds_b),
      .done  (ds_done),
      .res   (ds_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // shared combinational terms
   always_comb begin
      ex = lenb_ff ? ((CW+1)'(p2x_ff) - (CW+1)'(p1x_ff))
                   : ((CW+1)'(p0x_ff) - (CW+1)'(p1x_ff));
      ey = lenb_ff ? ((CW+1)'(p2y_ff) - (CW+1)'(p1y_ff))
                   : ((CW+1)'(p0y_ff) - (CW+1)'(p1y_ff));

      ty_ext = PW'(ty_ff);
      lo_y   = ty_ext - PW'($signed({1'b0, hw_ff}));
      hi_y   = ty_ext + PW'($signed({1'b0, hw_ff}));
      if (kind_ff == KIND_STROKE) begin
         skip = (PW'(p0y_ff) <= lo_y && PW'(p1y_ff) <= lo_y && PW'(p2y_ff) <= lo_y) ||
                (PW'(p0y_ff) >= hi_y && PW'(p1y_ff) >= hi_y && PW'(p2y_ff) >= hi_y);
      end else begin
         skip = (p0y_ff <= ty_ff && p1y_ff <= ty_ff && p2y_ff <= ty_ff) ||
                (p0y_ff >= ty_ff && p1y_ff >= ty_ff && p2y_ff >= ty_ff);
      end

      straddle = (ay_ff < ty_ext) != (by_ff < ty_ext);
      // acc holds (ty-ay)*(bx-ax), prod holds (tx-ax)*(by-ay)
      hit = (by_ff > ay_ff) ? (acc_ff < prod_ff) : (acc_ff > prod_ff);

      // round to nearest, ties up: floor((acc + 2^31) / 2^32)
      rsum = acc_ff + (AW'(1) <<< (ROUND_SHIFT - 1));
      // truncate toward zero on divide by 512
      tsum = acc_ff + (acc_ff[AW-1] ? ((AW'(1) <<< TAN_SHIFT) - AW'(1)) : AW'(0));

      prod_mag = prod_ff[AW-1] ? AW'(-prod_ff) : AW'(prod_ff);
      u_val    = TW'(T_ONE) - t_ff;

      slen = len_ff[LW-1:LEN_SHIFT];
      if (slen == '0) begin
         n_clamped = NW'(1);
      end else if (slen > SLW'(MAX_STEPS)) begin
         n_clamped = NW'(MAX_STEPS);
      end else begin
         n_clamped = slen[NW-1:0];
      end

      qmag  = $signed({1'b0, ds_res[QW-2:0]});
      hw_op = MW'($signed({1'b0, hw_ff}));

      if (dot_ff == DOT_BEZ_X || dot_ff == DOT_TAN_X) begin
         dot_c0 = MW'(p0x_ff);
         dot_c1 = MW'(p1x_ff);
         dot_c2 = MW'(p2x_ff);
      end else begin
         dot_c0 = MW'(p0y_ff);
         dot_c1 = MW'(p1y_ff);
         dot_c2 = MW'(p2y_ff);
      end
      if (dot_ff == DOT_BEZ_X || dot_ff == DOT_BEZ_Y) begin
         dot_w0 = w0_ff;
         dot_w1 = w1_ff;
         dot_w2 = w2_ff;
      end else begin
         dot_w0 = MW'(tw0_ff);
         dot_w1 = MW'(tw1_ff);
         dot_w2 = MW'(tw2_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (pcht_kind_type'(req_kind))
                  KIND_CLEAR: state_in = ST_DONE;
                  KIND_LINE:  state_in = ST_CH1;
                  default:    state_in = ST_CHK;
               endcase
            end
         end
         ST_CHK:   state_in = skip ? ST_DONE : ST_L1;
         ST_L1:    state_in = ST_L2;
         ST_L2:    state_in = ST_L3;
         ST_L3:    state_in = ST_L4;
         ST_L4:    state_in = ST_L5;
         ST_L5: begin
            if (ds_done) begin
               state_in = lenb_ff ? ST_NSTEP : ST_L1;
            end
         end
         ST_NSTEP: state_in = ST_NDIV;
         ST_NDIV:  state_in = ST_NWAIT;
         ST_NWAIT: begin
            if (ds_done) begin
               if (kind_ff == KIND_STROKE && n_ff == NW'(1)) begin
                  state_in = ST_FFA;
               end else begin
                  state_in = ST_W1;
               end
            end
         end
         ST_W1:    state_in = ST_W2;
         ST_W2:    state_in = ST_W3;
         ST_W3:    state_in = ST_W4;
         ST_W4:    state_in = ST_D0;
         ST_D0:    state_in = ST_D1;
         ST_D1:    state_in = ST_D2;
         ST_D2:    state_in = ST_D3;
         ST_D3:    state_in = ret_ff;
         ST_QX:    state_in = ST_D0;
         ST_QY:    state_in = (kind_ff == KIND_STROKE) ? ST_D0 : ST_PCH;
         ST_PCH:   state_in = ST_CH1;
         ST_PNEXT: state_in = (k_ff == n_ff) ? ST_PFIN : ST_W1;
         ST_PFIN:  state_in = ST_CH1;
         ST_TX:    state_in = ST_D0;
         ST_TY:    state_in = ST_N1;
         ST_N1:    state_in = ST_N2;
         ST_N2:    state_in = ST_N3;
         ST_N3:    state_in = ST_N4;
         ST_N4:    state_in = ST_N5;
         ST_N5: begin
            if (ds_done) begin
               state_in = (ds_res == '0) ? ST_FCA : ST_O1;
            end
         end
         ST_O1:    state_in = ST_O2;
         ST_O2:    state_in = ST_O3;
         ST_O3:    state_in = ds_done ? ST_O4 : ST_O3;
         ST_O4:    state_in = ST_O5;
         ST_O5:    state_in = ST_O6;
         ST_O6:    state_in = ds_done ? ST_FCA : ST_O6;
         ST_FCA:   state_in = ST_CH1;
         ST_FCB:   state_in = ST_CH1;
         ST_FNEXT: state_in = (k_ff + NW'(1) == n_ff) ? ST_FFA : ST_W1;
         ST_FFA:   state_in = ST_CH1;
         ST_FFB:   state_in = ST_CH1;
         ST_CH1:   state_in = straddle ? ST_CH2 : ret_ff;
         ST_CH2:   state_in = ST_CH3;
         ST_CH3:   state_in = ret_ff;
         ST_DONE:  state_in = out_free ? ST_IDLE : ST_DONE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // multiplier operands and divide / root requests
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      ds_req    = '{start: 1'b0, op: DS_DIV};
      ds_a      = '0;
      ds_b      = '0;
      case (state_ff)
         ST_L1: begin
            mul_a = MW'(ex);
            mul_b = MW'(ex);
         end
         ST_L2: begin
            mul_a = MW'(ey);
            mul_b = MW'(ey);
         end
         ST_L4, ST_N4: begin
            ds_req = '{start: 1'b1, op: DS_SQRT};
            ds_a   = acc_ff[DW-1:0];
         end
         ST_NDIV: begin
            ds_req = '{start: 1'b1, op: DS_DIV};
            ds_a   = T_ONE;
            ds_b   = DVW'(n_ff) + DVW'(1);
         end
         ST_W1: begin
            mul_a = MW'($signed({1'b0, t_ff}));
            mul_b = MW'($signed({1'b0, t_ff}));
         end
         ST_W2: begin
            mul_a = MW'($signed({1'b0, u_val}));
            mul_b = MW'($signed({1'b0, u_val}));
         end
         ST_D0: begin
            mul_a = dot_c0;
            mul_b = dot_w0;
         end
         ST_D1: begin
            mul_a = dot_c1;
            mul_b = dot_w1;
         end
         ST_D2: begin
            mul_a = dot_c2;
            mul_b = dot_w2;
         end
         ST_N1: begin
            mul_a = MW'(dx_ff);
            mul_b = MW'(dx_ff);
         end
         ST_N2: begin
            mul_a = MW'(dy_ff);
            mul_b = MW'(dy_ff);
         end
         ST_O1: begin
            mul_a = MW'(dy_ff);
            mul_b = hw_op;
         end
         ST_O4: begin
            mul_a = MW'(dx_ff);
            mul_b = hw_op;
         end
         ST_O2, ST_O5: begin
            ds_req = '{start: 1'b1, op: DS_DIV};
            ds_a   = prod_mag[DW-1:0];
            ds_b   = nm_ff;
         end
         ST_CH1: begin
            mul_a = MW'(ty_ext) - MW'(ay_ff);
            mul_b = MW'(bx_ff) - MW'(ax_ff);
         end
         ST_CH2: begin
            mul_a = MW'(tx_ff) - MW'(ax_ff);
            mul_b = MW'(by_ff) - MW'(ay_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[AW-1:0];

   // datapath
   always_comb begin
      ret_in   = ret_ff;
      dot_in   = dot_ff;
      kind_in  = kind_ff;
      p0x_in   = p0x_ff;
      p0y_in   = p0y_ff;
      p1x_in   = p1x_ff;
      p1y_in   = p1y_ff;
      p2x_in   = p2x_ff;
      p2y_in   = p2y_ff;
      hw_in    = hw_ff;
      sox_in   = sox_ff;
      soy_in   = soy_ff;
      eox_in   = eox_ff;
      eoy_in   = eoy_ff;
      tx_in    = tx_ff;
      ty_in    = ty_ff;
      cross_in = cross_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;
      lenb_in  = lenb_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      step_in  = step_ff;
      t_in     = t_ff;
      w0_in    = w0_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      tw0_in   = tw0_ff;
      tw1_in   = tw1_ff;
      tw2_in   = tw2_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      nm_in    = nm_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      neg_in   = neg_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      lax_in   = lax_ff;
      lay_in   = lay_ff;
      lbx_in   = lbx_ff;
      lby_in   = lby_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_count_in = rsp_count_ff;

      if (csr_write) begin
         case (pcht_reg_type'(csr_index))
            REG_TEST_X: tx_in = $signed(csr_data);
            REG_TEST_Y: ty_in = $signed(csr_data);
            default:    tx_in = tx_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in = pcht_kind_type'(req_kind);
               p0x_in  = req_p0_x;
               p0y_in  = req_p0_y;
               p1x_in  = req_p1_x;
               p1y_in  = req_p1_y;
               p2x_in  = req_p2_x;
               p2y_in  = req_p2_y;
               hw_in   = req_half_width;
               sox_in  = req_start_off_x;
               soy_in  = req_start_off_y;
               eox_in  = req_end_off_x;
               eoy_in  = req_end_off_y;
               ax_in   = PW'(req_p0_x);
               ay_in   = PW'(req_p0_y);
               bx_in   = PW'(req_p1_x);
               by_in   = PW'(req_p1_y);
               ret_in  = ST_DONE;
               lenb_in = 1'b0;
               if (pcht_kind_type'(req_kind) == KIND_CLEAR) begin
                  cross_in = '0;
               end
            end
         end
         ST_L2, ST_N2, ST_D1, ST_CH2: acc_in = prod_ff;
         ST_L3, ST_N3, ST_D2, ST_D3:  acc_in = acc_ff + prod_ff;
         ST_L5: begin
            if (ds_done) begin
               len_in  = lenb_ff ? (len_ff + LW'(ds_res[LW-2:0])) : LW'(ds_res[LW-2:0]);
               lenb_in = 1'b1;
            end
         end
         ST_NSTEP: n_in = n_clamped;
         ST_NWAIT: begin
            if (ds_done) begin
               step_in = ds_res[SW-1:0];
               t_in    = TW'(ds_res[SW-1:0]);
               k_in    = NW'(1);
               if (kind_ff == KIND_STROKE) begin
                  lax_in = PW'(p0x_ff) + PW'(sox_ff);
                  lay_in = PW'(p0y_ff) + PW'(soy_ff);
                  lbx_in = PW'(p0x_ff) - PW'(sox_ff);
                  lby_in = PW'(p0y_ff) - PW'(soy_ff);
               end else begin
                  lax_in = PW'(p0x_ff);
                  lay_in = PW'(p0y_ff);
               end
            end
         end
         ST_W2: w2_in = prod_ff[MW-1:0];
         ST_W3: w0_in = prod_ff[MW-1:0];
         ST_W4: begin
            // weights of the curve sum to one
            w1_in  = WEIGHT_ONE - w0_ff - w2_ff;
            tw0_in = $signed({1'b0, t_ff}) - TWW'($signed({1'b0, T_ONE[TW-1:0]}));
            tw1_in = TWW'($signed({1'b0, T_ONE[TW-1:0]})) - $signed({t_ff, 1'b0});
            tw2_in = $signed({1'b0, t_ff});
            dot_in = DOT_BEZ_X;
            ret_in = ST_QX;
         end
         ST_QX: begin
            qx_in  = rsum[ROUND_SHIFT +: QW];
            dot_in = DOT_BEZ_Y;
            ret_in = ST_QY;
         end
         ST_QY: begin
            qy_in  = rsum[ROUND_SHIFT +: QW];
            dot_in = DOT_TAN_X;
            ret_in = ST_TX;
         end
         ST_PCH: begin
            ax_in  = lax_ff;
            ay_in  = lay_ff;
            bx_in  = PW'(qx_ff);
            by_in  = PW'(qy_ff);
            ret_in = ST_PNEXT;
         end
         ST_PNEXT: begin
            lax_in = PW'(qx_ff);
            lay_in = PW'(qy_ff);
            k_in   = k_ff + NW'(1);
            t_in   = t_ff + TW'(step_ff);
         end
         ST_PFIN: begin
            ax_in  = lax_ff;
            ay_in  = lay_ff;
            bx_in  = PW'(p2x_ff);
            by_in  = PW'(p2y_ff);
            ret_in = ST_DONE;
         end
         ST_TX: begin
            dx_in  = tsum[TAN_SHIFT +: DXW];
            dot_in = DOT_TAN_Y;
            ret_in = ST_TY;
         end
         ST_TY: dy_in = tsum[TAN_SHIFT +: DXW];
         ST_N5: begin
            if (ds_done) begin
               nm_in = ds_res[DVW-1:0];
               ox_in = '0;
               oy_in = '0;
            end
         end
         ST_O2: neg_in = ~prod_ff[AW-1];
         ST_O3: begin
            if (ds_done) begin
               ox_in = neg_ff ? -qmag : qmag;
            end
         end
         ST_O5: neg_in = prod_ff[AW-1];
         ST_O6: begin
            if (ds_done) begin
               oy_in = neg_ff ? -qmag : qmag;
            end
         end
         ST_FCA: begin
            ax_in  = lax_ff;
            ay_in  = lay_ff;
            bx_in  = PW'(qx_ff) + PW'(ox_ff);
            by_in  = PW'(qy_ff) + PW'(oy_ff);
            ret_in = ST_FCB;
         end
         ST_FCB: begin
            ax_in  = PW'(qx_ff) - PW'(ox_ff);
            ay_in  = PW'(qy_ff) - PW'(oy_ff);
            bx_in  = lbx_ff;
            by_in  = lby_ff;
            ret_in = ST_FNEXT;
         end
         ST_FNEXT: begin
            lax_in = PW'(qx_ff) + PW'(ox_ff);
            lay_in = PW'(qy_ff) + PW'(oy_ff);
            lbx_in = PW'(qx_ff) - PW'(ox_ff);
            lby_in = PW'(qy_ff) - PW'(oy_ff);
            k_in   = k_ff + NW'(1);
            t_in   = t_ff + TW'(step_ff);
         end
         ST_FFA: begin
            ax_in  = lax_ff;
            ay_in  = lay_ff;
            bx_in  = PW'(p2x_ff) + PW'(eox_ff);
            by_in  = PW'(p2y_ff) + PW'(eoy_ff);
            ret_in = ST_FFB;
         end
         ST_FFB: begin
            ax_in  = PW'(p2x_ff) - PW'(eox_ff);
            ay_in  = PW'(p2y_ff) - PW'(eoy_ff);
            bx_in  = lbx_ff;
            by_in  = lby_ff;
            ret_in = ST_DONE;
         end
         ST_CH3: begin
            if (hit) begin
               cross_in = cross_ff + CNTW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cross_ff;
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cross_ff     <= '0;
         tx_ff        <= '0;
         ty_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cross_ff     <= cross_in;
         tx_ff        <= tx_in;
         ty_ff        <= ty_in;
      end
      ret_ff  <= ret_in;
      dot_ff  <= dot_in;
      kind_ff <= kind_in;
      p0x_ff  <= p0x_in;
      p0y_ff  <= p0y_in;
      p1x_ff  <= p1x_in;
      p1y_ff  <= p1y_in;
      p2x_ff  <= p2x_in;
      p2y_ff  <= p2y_in;
      hw_ff   <= hw_in;
      sox_ff  <= sox_in;
      soy_ff  <= soy_in;
      eox_ff  <= eox_in;
      eoy_ff  <= eoy_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      len_ff  <= len_in;
      lenb_ff <= lenb_in;
      n_ff    <= n_in;
      k_ff    <= k_in;
      step_ff <= step_in;
      t_ff    <= t_in;
      w0_ff   <= w0_in;
      w1_ff   <= w1_in;
      w2_ff   <= w2_in;
      tw0_ff  <= tw0_in;
      tw1_ff  <= tw1_in;
      tw2_ff  <= tw2_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      nm_ff   <= nm_in;
      ox_ff   <= ox_in;
      oy_ff   <= oy_in;
      neg_ff  <= neg_in;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      bx_ff   <= bx_in;
      by_ff   <= by_in;
      lax_ff  <= lax_in;
      lay_ff  <= lay_in;
      lbx_ff  <= lbx_in;
      lby_ff  <= lby_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_crossing_count = rsp_count_ff;
   assign rsp_inside_res     = rsp_count_ff[0];

endmodule

FILE: rtl/pcht_divsqrt.sv
// Shared restoring divider / integer square root, one result bit a cycle.
module pcht_divsqrt import pcht_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  pcht_ds_req_type req,
   input  logic [DW-1:0]   a,
   input  logic [DVW-1:0]  b,
   output logic            done,
   output logic [DW-1:0]   res
);

   localparam int RW = 36;
   localparam logic [6:0] DIV_STEPS  = 7'd64;
   localparam logic [6:0] SQRT_STEPS = 7'd32;

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   pcht_ds_op_type op_ff, op_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [DW-1:0]  x_ff, x_in;
   logic [RW-1:0]  rem_ff, rem_in;
   logic [DW-1:0]  res_ff, res_in;
   logic [DVW-1:0] div_ff, div_in;

   logic [RW-1:0]  rem_sh;
   logic [RW-1:0]  trial;
   logic [RW:0]    diff;
   logic           ge;

   always_comb begin
      if (op_ff == DS_SQRT) begin
         rem_sh = {rem_ff[RW-3:0], x_ff[DW-1 -: 2]};
         trial  = {res_ff[RW-3:0], 2'b01};
      end else begin
         rem_sh = {rem_ff[RW-2:0], x_ff[DW-1]};
         trial  = RW'(div_ff);
      end
      diff = {1'b0, rem_sh} - {1'b0, trial};
      ge   = ~diff[RW];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      div_in  = div_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         cnt_in  = (req.op == DS_SQRT) ? SQRT_STEPS : DIV_STEPS;
         x_in    = a;
         rem_in  = '0;
         res_in  = '0;
         div_in  = b;
      end else if (busy_ff) begin
         x_in   = (op_ff == DS_SQRT) ? {x_ff[DW-3:0], 2'b00} : {x_ff[DW-2:0], 1'b0};
         rem_in = ge ? diff[RW-1:0] : rem_sh;
         res_in = {res_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

endmodule
